// ===== src/bst_pkg.sv =====
// Shared types, constants and codes of the beacon sample table.
package bst_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int REPORT_MAX  = 4;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int RANK_W = ($clog2(REPORT_MAX + 1) > 2) ? $clog2(REPORT_MAX + 1) : 2;

  localparam int OP_W    = 2;
  localparam int LEN_W   = 16;
  localparam int FC_W    = 16;
  localparam int BSSID_W = 48;
  localparam int TSF_W   = 64;
  localparam int RSSI_W  = 8;
  localparam int RTC_W   = 32;
  localparam int CHAN_W  = 4;
  localparam int OFS_W   = 56;

  localparam int MS_PER_SEC = 1000;
  localparam int US_PER_MS  = 1000;
  localparam int PROD_W     = RTC_W + $clog2(MS_PER_SEC);

  localparam int DIV_CHUNK_W = 16;
  localparam int DIV_STEPS   = TSF_W / DIV_CHUNK_W;
  localparam int DIV_STEP_W  = $clog2(DIV_STEPS);
  localparam int DIV_REM_W   = $clog2(US_PER_MS);
  localparam int DIV_PART_W  = DIV_REM_W + DIV_CHUNK_W;
  localparam int DIV_SHIFT   = DIV_PART_W + DIV_REM_W;
  localparam int DIV_RECIP_W = DIV_SHIFT - DIV_REM_W + 1;
  localparam int DIV_PROD_W  = DIV_PART_W + DIV_RECIP_W;
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + 64'(US_PER_MS) - 64'd1) / 64'(US_PER_MS);

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_BEACON = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [LEN_W-1:0] MIN_FRAME_LEN     = 16'd32;
  localparam logic [1:0]       FC_TYPE_MGMT      = 2'd0;
  localparam logic [3:0]       FC_SUBTYPE_BEACON = 4'd8;
  localparam logic [7:0]       BCAST_BYTE        = 8'hFF;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [LEN_W-1:0]         frame_length;
    logic [FC_W-1:0]          frame_control;
    logic [BSSID_W-1:0]       bssid;
    logic [TSF_W-1:0]         tsf;
    logic signed [RSSI_W-1:0] rssi;
    logic [RTC_W-1:0]         rtc_now_sec;
    logic [CHAN_W-1:0]        scan_channel;
  } in_t;

  typedef struct packed {
    logic                    record_valid;
    logic [1:0]              rank;
    logic [BSSID_W-1:0]      out_bssid;
    logic [CHAN_W-1:0]       out_channel;
    logic [TSF_W-1:0]        out_tsf;
    logic signed [OFS_W-1:0] offset_ms;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic [BSSID_W-1:0]       bssid;
    logic [CHAN_W-1:0]        channel;
    logic signed [RSSI_W-1:0] rssi;
    logic [TSF_W-1:0]         tsf;
    logic [RTC_W-1:0]         rtc_sec;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DIV,
    S_EMIT
  } state_t;

endpackage

// ===== src/bst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bst_div.sv =====
// Chunked divider that turns a microsecond timestamp into milliseconds.
module bst_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bst_pkg::TSF_W-1:0] dividend,
  output logic                      done,
  output logic [bst_pkg::TSF_W-1:0] quotient
);
  import bst_pkg::*;

  logic                   busy_r;
  logic                   done_r;
  logic                   phase_r;
  logic [DIV_STEP_W-1:0]  step_r;
  logic [DIV_REM_W-1:0]   rem_r;
  logic [TSF_W-1:0]       num_r;
  logic [TSF_W-1:0]       quo_r;
  logic [DIV_CHUNK_W-1:0] qd_r;
  logic [DIV_PART_W-1:0]  part;
  logic [DIV_PROD_W-1:0]  prod;
  logic [DIV_PART_W-1:0]  back;

  // Each step divides the running remainder joined with the next 16 bits of the
  // dividend, first by a reciprocal multiplication and then by taking back the remainder.
  assign part = {rem_r, num_r[TSF_W-1 -: DIV_CHUNK_W]};
  assign prod = DIV_PROD_W'(part) * DIV_PROD_W'(DIV_RECIP);
  assign back = DIV_PART_W'(qd_r) * DIV_PART_W'(US_PER_MS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && phase_r && step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r  <= '0;
      phase_r <= 1'b0;
      rem_r   <= '0;
      num_r   <= dividend;
    end else if (busy_r) begin
      phase_r <= !phase_r;
      if (!phase_r) begin
        qd_r <= prod[DIV_SHIFT +: DIV_CHUNK_W];
      end else begin
        rem_r  <= DIV_REM_W'(part - back);
        quo_r  <= {quo_r[TSF_W-DIV_CHUNK_W-1:0], qd_r};
        num_r  <= {num_r[TSF_W-DIV_CHUNK_W-1:0], {DIV_CHUNK_W{1'b0}}};
        step_r <= step_r + DIV_STEP_W'(1);
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef NO_ASSERTIONS
  a_start_begins: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && step_r == '0 && !phase_r)
    else $error("Divider did not begin after a start.");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("Divider finished while still busy.");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("Divider finished without having run.");
`endif

endmodule

// ===== src/beacon_sample_table_core.sv =====
// Top level of the beacon sample table: control, table scan and result register.
//
// The block takes one request at a time. A clear request, an op code of three and a
// beacon that fails the frame filters are done without stalling the input. A beacon that passes
// walks the n stored entries through the single read port of the table RAM and then
// writes the updated or new entry back; a new entry is dropped when the table is full.
// On an empty table it is written without a scan. A report repeats a scan of the
// table for each ranked entry, runs the millisecond divider and loads the result
// register, holding while the output is stalled. An empty table gives a single result
// with record_valid low and last set, without a scan.
// The entry count is cleared by reset, so no clearing pass of the RAM is needed.
module beacon_sample_table_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bst_pkg::out_t out_data
);
  import bst_pkg::*;

  state_t             state_r;
  state_t             state_nxt;
  logic [CNT_W-1:0]   count_r;
  in_t                req_r;
  logic               match_r;
  logic [IDX_W-1:0]   match_idx_r;
  entry_t             match_ent_r;
  logic [CNT_W-1:0]   rd_cnt_r;
  logic               dv_r;
  logic [IDX_W-1:0]   di_r;
  logic               found_r;
  entry_t             best_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic signed [RSSI_W-1:0] prev_rssi_r;
  logic [IDX_W-1:0]   prev_idx_r;
  logic [RANK_W-1:0]  rank_r;
  logic [RANK_W-1:0]  todo_r;
  logic               empty_r;
  logic [PROD_W-1:0]  prod_r;
  out_t               out_r;
  logic               out_valid_r;

  logic               accept;
  logic               beacon_ok;
  logic               issue_done;
  logic               scan_done;
  logic               can_load;
  logic               final_rank;
  logic               eligible;
  logic               better;
  logic [RANK_W-1:0]  todo_calc;
  entry_t             rd_data;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               div_start;
  logic               div_done;
  logic [TSF_W-1:0]   div_quo;
  logic               out_load;

  assign accept = in_valid && !in_stall;

  assign beacon_ok = (in_data.frame_length >= MIN_FRAME_LEN)
                  && (in_data.frame_control[3:2] == FC_TYPE_MGMT)
                  && (in_data.frame_control[7:4] == FC_SUBTYPE_BEACON)
                  && (in_data.bssid[47:40] != BCAST_BYTE)
                  && (in_data.bssid[47:24] != '0)
                  && (in_data.tsf != '0);

  assign issue_done = (rd_cnt_r == count_r);
  assign scan_done  = issue_done && !dv_r;
  assign can_load   = !out_valid_r || !out_stall;
  assign final_rank = empty_r || ((rank_r + RANK_W'(1)) == todo_r);
  assign todo_calc  = (int'(count_r) < REPORT_MAX) ? RANK_W'(count_r) : RANK_W'(REPORT_MAX);

  // Selection order is descending RSSI with ties in table order; each rank takes
  // the first entry that follows the previous pick in that order.
  assign eligible = (rank_r == '0)
                 || (rd_data.rssi < prev_rssi_r)
                 || ((rd_data.rssi == prev_rssi_r) && (di_r > prev_idx_r));
  assign better   = !found_r || (rd_data.rssi > best_r.rssi);

  bst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  bst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (best_r.tsf),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.op)
            OP_BEACON: begin
              if (beacon_ok) begin
                state_nxt = (count_r == '0) ? S_WRITE : S_SCAN;
              end
            end
            OP_REPORT: begin
              state_nxt = (count_r == '0) ? S_EMIT : S_SCAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = (req_r.op == OP_BEACON) ? S_WRITE : S_DIV;
        end
      end
      S_WRITE: state_nxt = S_IDLE;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          state_nxt = final_rank ? S_IDLE : S_SCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    rd_en     = (state_r == S_SCAN) && !issue_done;
    wr_en     = (state_r == S_WRITE) && (match_r || count_r != CNT_W'(TABLE_DEPTH));
    wr_addr   = match_r ? match_idx_r : IDX_W'(count_r);
    div_start = (state_r == S_SCAN) && scan_done && (req_r.op == OP_REPORT);
    out_load  = (state_r == S_EMIT) && can_load;
    if (match_r) begin
      wr_data         = match_ent_r;
      wr_data.tsf     = req_r.tsf;
      wr_data.rtc_sec = req_r.rtc_now_sec;
      if (req_r.rssi > match_ent_r.rssi) begin
        wr_data.rssi = req_r.rssi;
      end
    end else begin
      wr_data.bssid   = req_r.bssid;
      wr_data.channel = req_r.scan_channel;
      wr_data.rssi    = req_r.rssi;
      wr_data.tsf     = req_r.tsf;
      wr_data.rtc_sec = req_r.rtc_now_sec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rank_r      <= '0;
      dv_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= rd_en;
      if (accept && in_data.op == OP_CLEAR) begin
        count_r <= '0;
      end else if (wr_en && !match_r) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        rank_r <= '0;
      end else if (out_load && !final_rank) begin
        rank_r <= rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    di_r <= rd_cnt_r[IDX_W-1:0];
    if (accept) begin
      req_r    <= in_data;
      match_r  <= 1'b0;
      rd_cnt_r <= '0;
      found_r  <= 1'b0;
      empty_r  <= (count_r == '0);
      todo_r   <= todo_calc;
    end else begin
      if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
      if (dv_r) begin
        if (req_r.op == OP_BEACON) begin
          if (rd_data.bssid == req_r.bssid) begin
            match_r     <= 1'b1;
            match_idx_r <= di_r;
            match_ent_r <= rd_data;
          end
        end else if (eligible && better) begin
          found_r    <= 1'b1;
          best_r     <= rd_data;
          best_idx_r <= di_r;
        end
      end
      if (out_load && !final_rank) begin
        prev_rssi_r <= best_r.rssi;
        prev_idx_r  <= best_idx_r;
        rd_cnt_r    <= '0;
        found_r     <= 1'b0;
      end
    end
    if (div_start) begin
      prod_r <= PROD_W'(best_r.rtc_sec) * PROD_W'(MS_PER_SEC);
    end
    if (out_load) begin
      if (empty_r) begin
        out_r.record_valid <= 1'b0;
        out_r.rank         <= '0;
        out_r.out_bssid    <= '0;
        out_r.out_channel  <= '0;
        out_r.out_tsf      <= '0;
        out_r.offset_ms    <= '0;
        out_r.last         <= 1'b1;
      end else begin
        out_r.record_valid <= 1'b1;
        out_r.rank         <= rank_r[1:0];
        out_r.out_bssid    <= best_r.bssid;
        out_r.out_channel  <= best_r.channel;
        out_r.out_tsf      <= best_r.tsf;
        out_r.offset_ms    <= $signed(OFS_W'(prod_r) - div_quo[OFS_W-1:0]);
        out_r.last         <= final_rank;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_CLEAR) |=> count_r == '0)
    else $error("Clear request did not empty the table.");

  a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && req_r.op == OP_REPORT) |-> rank_r < todo_r)
    else $error("Report scan started beyond the last rank.");
`endif

endmodule
